// ----- rtl/keyed_mac_bit_cipher_unit_assert.svh -----
// Assertion macros shared by the RTL of the keyed MAC unit.
`ifndef KEYED_MAC_BIT_CIPHER_UNIT_ASSERT_SVH
`define KEYED_MAC_BIT_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KMBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KMBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kmbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kmbc_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MacW   = 32;
  localparam int unsigned CntW   = $clog2(MacW);

  localparam logic [15:0] TopTaps   = 16'hC533;
  localparam logic [15:0] TopInit   = 16'hE012;
  localparam logic [7:0]  BotInit   = 8'h4C;
  localparam logic [7:0]  KeyMask   = 8'h4C;
  localparam logic [7:0]  LeftOfs   = 8'hEC;
  localparam logic [7:0]  RightOfs  = 8'h21;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StAbsorb = 3'b010,
    StMac    = 3'b100
  } state_e;

  typedef struct packed {
    logic [7:0]  left;
    logic [7:0]  right;
    logic [15:0] top;
    logic [7:0]  bottom;
  } cs_t;

  function automatic cs_t cipher_init(logic [KeyW-1:0] key);
    logic [7:0] k0;
    cs_t        s;
    k0       = key[7:0] ^ KeyMask;
    s.left   = k0 + LeftOfs;
    s.right  = k0 + RightOfs;
    s.top    = TopInit;
    s.bottom = BotInit;
    return s;
  endfunction

  // Key byte select; bit 7 of r is the first tap of the published numbering.
  function automatic logic [2:0] select3(logic x, logic y, logic [7:0] r);
    logic z0;
    logic z1;
    logic z2;
    z0 = (r[7] & r[5]) ^ (r[6] & ~r[4]) ^ (r[5] | r[3]);
    z1 = (r[7] | r[5]) ^ (r[2] | r[0]) ^ r[6] ^ r[1] ^ x ^ y;
    z2 = (r[4] & ~r[2]) ^ (r[3] & r[1]) ^ r[0] ^ x;
    return {z0, z1, z2};
  endfunction

  function automatic cs_t cipher_step(cs_t s, logic y, logic [KeyW-1:0] key);
    logic       t_fb;
    logic       top_in;
    logic       bot_in;
    logic [2:0] sel;
    logic [7:0] kb;
    cs_t        n;
    t_fb     = ^(s.top & TopTaps);
    top_in   = t_fb ^ s.right[7] ^ s.right[3];
    bot_in   = s.bottom[0] ^ s.bottom[4] ^ s.bottom[5] ^ s.bottom[6] ^ s.right[0];
    n.top    = {top_in, s.top[15:1]};
    n.bottom = {bot_in, s.bottom[7:1]};
    sel      = select3(t_fb, y, s.right);
    kb       = key[{sel, 3'b000} +: ByteW];
    n.right  = (kb ^ n.bottom) + s.left;
    n.left   = n.right + s.right;
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/keyed_mac_bit_cipher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keyed MAC unit: absorbs message bytes (bit 0 first) into a 40-bit bit cipher
// under the 64-bit key and returns a 32-bit MAC after the byte flagged last.
// One cipher step engine is reused for every step under a small sequencer: a
// byte is latched and then takes eight steps; after the byte flagged last the
// unit squeezes the 32 MAC bits out into the output register, held back while
// an earlier MAC is still waiting there. The unit holds in_stall_o high while
// a byte is in work. The first byte of each message reloads the cipher state
// from key byte 0. Write the key only while the unit is idle.
module keyed_mac_bit_cipher_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            key_we_i,
  input  wire  [kmbc_pkg::KeyW-1:0]      key_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [kmbc_pkg::ByteW-1:0]     data_byte_i,
  input  wire                            last_byte_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [kmbc_pkg::MacW-1:0]      mac_o
);
  import kmbc_pkg::*;

  logic [KeyW-1:0]  key_q;
  state_e           state_q, state_d;
  cs_t              cs_q, cs_d;
  cs_t              cs_next;
  logic [ByteW-1:0] data_q, data_d;
  logic             last_q, last_d;
  logic             fresh_q, fresh_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [MacW-1:0]  mac_sr_q, mac_sr_d;
  logic             out_valid_q, out_valid_d;
  logic [MacW-1:0]  mac_q, mac_d;
  logic             in_xfer;
  logic             out_free;
  logic             step_y;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign mac_o       = mac_q;
  // The output slot frees up this cycle if empty or being taken now.
  assign out_free    = !out_valid_q || !out_stall_i;

  // The shared step engine: feed the next message bit, zero while squeezing.
  assign step_y  = (state_q == StAbsorb) ? data_q[0] : 1'b0;
  assign cs_next = cipher_step(cs_q, step_y, key_q);

  always_comb begin
    state_d     = state_q;
    cs_d        = cs_q;
    data_d      = data_q;
    last_d      = last_q;
    fresh_d     = fresh_q;
    cnt_d       = cnt_q;
    mac_sr_d    = mac_sr_q;
    out_valid_d = out_valid_q;
    mac_d       = mac_q;

    // Drop the held MAC once its transfer completes.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          // Latch the byte; load the start state on the first byte of a message.
          data_d  = data_byte_i;
          last_d  = last_byte_i;
          cnt_d   = '0;
          state_d = StAbsorb;
          if (fresh_q) begin
            cs_d    = cipher_init(key_q);
            fresh_d = 1'b0;
          end
        end
      end
      StAbsorb: begin
        // One step per cycle, shifting the byte down bit by bit.
        cs_d   = cs_next;
        data_d = data_q >> 1;
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q[2:0] == 3'(ByteW - 1)) begin
          cnt_d   = '0;
          state_d = last_q ? StMac : StIdle;
        end
      end
      StMac: begin
        // Collect right bit 2 before each step, first bit ending at bit 0.
        if (cnt_q != CntW'(MacW - 1)) begin
          cs_d     = cs_next;
          mac_sr_d = {cs_q.right[2], mac_sr_q[MacW-1:1]};
          cnt_d    = cnt_q + CntW'(1);
        end else if (out_free) begin
          // No final step is taken here: the next byte reloads the state.
          mac_d       = {cs_q.right[2], mac_sr_q[MacW-1:1]};
          out_valid_d = 1'b1;
          fresh_d     = 1'b1;
          cnt_d       = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      state_q     <= StIdle;
      cs_q        <= '0;
      fresh_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (key_we_i) begin
        key_q <= key_i;
      end
      state_q     <= state_d;
      cs_q        <= cs_d;
      fresh_q     <= fresh_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    mac_sr_q <= mac_sr_d;
    mac_q    <= mac_d;
  end

`include "keyed_mac_bit_cipher_unit_assert.svh"

  `KMBC_ASSERT_SAME(a_state_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q), "state not one-hot")
  `KMBC_ASSERT_NEXT(a_accept_absorb, clk_i, rst_ni, in_xfer, (state_q == StAbsorb) && (cnt_q == '0), "accepted byte did not start absorbing")
  `KMBC_ASSERT_NEXT(a_mid_byte_idle, clk_i, rst_ni, (state_q == StAbsorb) && (cnt_q[2:0] == 3'(ByteW - 1)) && !last_q, (state_q == StIdle) && !out_valid_q == $past(!out_valid_q || !out_stall_i), "non-final byte did not return to idle")
  `KMBC_ASSERT_NEXT(a_mac_load, clk_i, rst_ni, (state_q == StMac) && (cnt_q == CntW'(MacW - 1)) && out_free, out_valid_q && fresh_q && (state_q == StIdle), "MAC not loaded at end of squeeze")
  `KMBC_ASSERT_SAME(a_fresh_idle, clk_i, rst_ni, state_q == StMac, !fresh_q, "message restart flagged during squeeze")

endmodule

`default_nettype wire

// ----- tb/tb_keyed_mac_bit_cipher_unit.sv -----
`timescale 1ns / 1ps

module tb_keyed_mac_bit_cipher_unit;

  import kmbc_pkg::*;

  // Cycles to let pass after the last result before touching the key: a
  // comfortable margin over a last byte's absorb and squeeze in the unit.
  localparam int SettleCycles = 60;
  // Generous run limit for about 1900 bytes.
  localparam int CycleLimit   = 1000000;
  localparam int MaxReports   = 100;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } msg_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;

  logic              key_we = 1'b0;
  logic [KeyW-1:0]   key_d = '0;
  logic              in_valid = 1'b0;
  logic [ByteW-1:0]  data_byte = '0;
  logic              last_byte = 1'b0;
  logic              out_stall = 1'b0;

  wire               in_stall;
  wire               out_valid;
  wire  [MacW-1:0]   mac;

  // Bytes waiting to be offered, and MACs waiting to come out.
  msg_byte_t         byte_q[$];
  logic [MacW-1:0]   mac_q[$];

  int                tx_idle_pct = 12;
  int                rx_idle_pct = 70;
  bit                tx_hold = 1'b0;
  int                error_count = 0;
  int                cycle_count = 0;

  // Predictor state: key shadow and the 40-bit cipher state.
  logic [KeyW-1:0]   shadow_key = '0;
  logic [7:0]        c_left = '0;
  logic [7:0]        c_right = '0;
  logic [15:0]       c_top = '0;
  logic [7:0]        c_bottom = '0;
  bit                c_fresh = 1'b1;

  keyed_mac_bit_cipher_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_we_i    (key_we),
    .key_i       (key_d),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .mac_o       (mac)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Key byte select from the right register; tap 0 is bit 7.
  function automatic logic [2:0] pick_key_byte(logic x, logic y, logic [7:0] r);
    logic s0;
    logic s1;
    logic s2;
    s0 = (r[7] & r[5]) ^ (r[6] & ~r[4]) ^ (r[5] | r[3]);
    s1 = (r[7] | r[5]) ^ (r[2] | r[0]) ^ r[6] ^ r[1] ^ x ^ y;
    s2 = (r[4] & ~r[2]) ^ (r[3] & r[1]) ^ r[0] ^ x;
    return {s0, s1, s2};
  endfunction

  // Advance the cipher state by one step with input bit y.
  function automatic void advance_cipher(logic y);
    logic       fb;
    logic       top_in;
    logic       bot_in;
    logic [2:0] sel;
    logic [7:0] nbot;
    logic [7:0] nright;
    fb      = ^(c_top & TopTaps);
    top_in  = fb ^ c_right[7] ^ c_right[3];
    bot_in  = c_bottom[0] ^ c_bottom[4] ^ c_bottom[5] ^ c_bottom[6] ^ c_right[0];
    nbot    = {bot_in, c_bottom[7:1]};
    sel     = pick_key_byte(fb, y, c_right);
    nright  = (shadow_key[{sel, 3'b000} +: 8] ^ nbot) + c_left;
    c_left  = nright + c_right;
    c_right = nright;
    c_top   = {top_in, c_top[15:1]};
    c_bottom = nbot;
  endfunction

  // Absorb one byte; after a last byte, queue the MAC it yields.
  function automatic void absorb_byte(logic [7:0] d, logic is_last);
    logic [7:0]      k0;
    logic [MacW-1:0] m;
    if (c_fresh) begin
      k0       = shadow_key[7:0] ^ 8'h4C;
      c_left   = k0 + 8'hEC;
      c_right  = k0 + 8'h21;
      c_top    = 16'hE012;
      c_bottom = 8'h4C;
      c_fresh  = 1'b0;
    end
    for (int i = 0; i < 8; i++) advance_cipher(d[i]);
    if (is_last) begin
      m = '0;
      for (int j = 0; j < MacW; j++) begin
        m[j] = c_right[2];
        advance_cipher(1'b0);
      end
      c_fresh = 1'b1;
      mac_q.push_back(m);
    end
  endfunction

  // Driver: hold a stalled transfer, drop the accepted one, offer the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      data_byte <= '0;
      last_byte <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) void'(byte_q.pop_front());
      if (byte_q.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
        in_valid  <= 1'b1;
        data_byte <= byte_q[0].data;
        last_byte <= byte_q[0].last;
      end else begin
        in_valid  <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Monitor: track key writes, predict on each accepted byte, check MACs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (key_we) shadow_key = key_d;
      if (in_valid && !in_stall) absorb_byte(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        if (mac_q.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: unexpected MAC, expected none, actual %h", $time, mac);
        end else begin
          if (mac !== mac_q[0]) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: MAC mismatch, expected %h, actual %h", $time, mac_q[0], mac);
          end
          void'(mac_q.pop_front());
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_keyed_mac_bit_cipher_unit: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || in_valid || mac_q.size() != 0);
  endtask

  // Drain, let the unit settle, then write the key.
  task automatic load_key(logic [KeyW-1:0] v);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    key_we <= 1'b1;
    key_d  <= v;
    @(posedge clk_i);
    key_we <= 1'b0;
  endtask

  task automatic push_byte(logic [7:0] d, logic is_last);
    msg_byte_t b;
    b.data = d;
    b.last = is_last;
    byte_q.push_back(b);
  endtask

  // Queue a message of n random bytes, the final one flagged last.
  task automatic push_message(int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
  endtask

  // Queue random messages until about n bytes are pending: mostly short
  // messages, now and then a long one.
  task automatic push_random_bytes(int n);
    int count;
    int len;
    count = 0;
    while (count < n) begin
      if ($urandom_range(19) == 0) len = $urandom_range(16, 40);
      else len = $urandom_range(1, 6);
      push_message(len);
      count += len;
    end
  endtask

  initial begin
    @(posedge rst_ni);

    // Directed: all-zero key, single bytes at the extremes, a short message.
    load_key({KeyW{1'b0}});
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b1);

    // All-ones key.
    load_key({KeyW{1'b1}});
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b1);

    // Distinct key bytes, then a key change in the middle of a message:
    // the loaded state is kept and the new key applies from there on.
    load_key(64'h0123_4567_89AB_CDEF);
    push_byte(8'h3C, 1'b1);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h96, 1'b0);
    load_key(64'hFEDC_BA98_7654_3210);
    push_byte(8'h69, 1'b1);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    // Random: three back-pressure profiles, two keys each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 12; rx_idle_pct = 70; end
        1: begin tx_idle_pct = 70; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int half = 0; half < 2; half++) begin
        load_key({32'($urandom), 32'($urandom)});
        if (ph == 0 && half == 0) begin
          push_random_bytes(150);
          // Pause the sender until every outstanding MAC has come out.
          while (byte_q.size() != 0) @(posedge clk_i);
          tx_hold = 1'b1;
          do @(posedge clk_i);
          while (in_valid || mac_q.size() != 0);
          tx_hold = 1'b0;
          push_random_bytes(166);
        end else begin
          push_random_bytes(316);
        end
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && mac_q.size() == 0) begin
      $display("tb_keyed_mac_bit_cipher_unit: PASS");
    end else begin
      $display("tb_keyed_mac_bit_cipher_unit: FAIL");
    end
    $finish;
  end

endmodule
